/* src/bfrlt_pkg.sv */
package bfrlt_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned COUNT_BITS_DEF  = 16;
  localparam int unsigned LIMIT_W         = 7;
  localparam int unsigned LIMIT_RESET     = 64;
  localparam int unsigned AMOUNT_W        = 16;
  localparam int unsigned LABEL_W         = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  // Source characters
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_LEFT   = 8'h3C;
  localparam logic [7:0] CHAR_RIGHT  = 8'h3E;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_OPEN   = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE  = 8'h5D;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_LEFT   = 3'd2,
    OP_RIGHT  = 3'd3,
    OP_OUTPUT = 3'd4,
    OP_INPUT  = 3'd5,
    OP_OPEN   = 3'd6,
    OP_CLOSE  = 3'd7
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_UNMATCHED = 2'd3
  } status_e;

  // Second part of a queued command, after the optional run flush
  typedef enum logic [1:0] {
    SEC_NONE  = 2'd0,
    SEC_OPEN  = 2'd1,
    SEC_CLOSE = 2'd2,
    SEC_ERR   = 2'd3
  } sec_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [2:0]          op_kind;
    logic [AMOUNT_W-1:0] amount;
    logic [1:0]          status;
    logic                has_op;
    logic                last;
  } out_t;

  typedef struct packed {
    logic                has_run;
    op_kind_e            run_kind;
    logic [AMOUNT_W-1:0] run_amount;
    sec_e                sec;
    logic [AMOUNT_W-1:0] sec_amount;
    status_e             sec_status;
  } cmd_t;

  typedef struct packed {
    logic     is_op;
    op_kind_e kind;
  } char_info_t;

  function automatic char_info_t classify(input logic [7:0] c);
    char_info_t r;
    r.is_op = 1'b1;
    r.kind  = OP_ADD;
    unique case (c)
      CHAR_PLUS:  r.kind = OP_ADD;
      CHAR_MINUS: r.kind = OP_SUB;
      CHAR_LEFT:  r.kind = OP_LEFT;
      CHAR_RIGHT: r.kind = OP_RIGHT;
      CHAR_DOT:   r.kind = OP_OUTPUT;
      CHAR_COMMA: r.kind = OP_INPUT;
      default:    r.is_op = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* src/bf_run_length_bracket_tokenizer.sv */
// Tokenizer for the eight-command esoteric language with run folding and
// bracket matching.
// Input channel: one source byte per request (in_valid_i / in_ready_o), with
//   end_of_input marking the end of text. Output channel: result requests
//   (out_valid_o / out_ready_i); an input byte yields zero, one or two results,
//   and the final one carries last.
// Throughput: one input byte per cycle while results drain; a byte that
//   yields two results (run flush plus bracket or error) holds the output
//   for both of them in turn, absorbed by the four-entry command queue.
// Path: the first result of a byte passes the front stage register (the
//   stack read is registered at the same edge), then the command queue,
//   then the output register.
// The label stack is a memory of STACK_DEPTH entries with one write and one
//   registered read port; the popped label is read at the edge that registers its command.
// Reset: clears run state, stack pointer, label counter and sticky error,
//   and sets the nesting limit to 64; stack contents are not cleared.
// Stall: when the receiver holds out_ready_i low, the output register holds,
//   the queue fills, and in_ready_o drops once the queue and front stage are
//   full. After an error, drop all further input until reset.
module bf_run_length_bracket_tokenizer #(
  parameter int unsigned STACK_DEPTH = bfrlt_pkg::STACK_DEPTH_DEF,
  parameter int unsigned COUNT_BITS  = bfrlt_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bfrlt_pkg::in_t                in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output bfrlt_pkg::out_t               out_o,
  input  logic                          cfg_we_i,
  input  logic [bfrlt_pkg::LIMIT_W-1:0] cfg_data_i
);

  logic            f_valid, q_full, q_valid, q_pop;
  bfrlt_pkg::cmd_t f_cmd, q_cmd;

  // Front: classify bytes, fold runs, manage the label stack
  bfrlt_front #(
    .STACK_DEPTH (STACK_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_o (f_valid),
    .cmd_full_i  (q_full),
    .cmd_o       (f_cmd)
  );

  // Decouple the front from output stalls
  bfrlt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid),
    .push_data_i (f_cmd),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .data_o      (q_cmd)
  );

  // Back: expand each command into its one or two results
  bfrlt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

/* src/bfrlt_front.sv */
module bfrlt_front #(
  parameter int unsigned STACK_DEPTH = bfrlt_pkg::STACK_DEPTH_DEF,
  parameter int unsigned COUNT_BITS  = bfrlt_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  bfrlt_pkg::in_t                     in_i,
  input  logic                               cfg_we_i,
  input  logic [bfrlt_pkg::LIMIT_W-1:0]      cfg_data_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_full_i,
  output bfrlt_pkg::cmd_t                    cmd_o
);

  localparam int unsigned SP_W  = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > bfrlt_pkg::LIMIT_W) ? CNT_W : bfrlt_pkg::LIMIT_W;

  logic [bfrlt_pkg::LIMIT_W-1:0] lim_q;
  logic                          pend_v_q, pend_v_d;
  bfrlt_pkg::op_kind_e           pend_kind_q, pend_kind_d;
  logic [COUNT_BITS-1:0]         pend_cnt_q, pend_cnt_d;
  logic [CNT_W-1:0]              sp_q, sp_d;
  logic [bfrlt_pkg::LABEL_W-1:0] label_q, label_d;
  logic                          err_q, err_d;
  logic                          st_v_q, st_v_d;
  bfrlt_pkg::cmd_t               st_q, st_d;
  logic [bfrlt_pkg::LABEL_W-1:0] rdata_q;
  logic [bfrlt_pkg::LABEL_W-1:0] stack_mem [STACK_DEPTH];

  logic                  accept, advance, push, pop, do_flush, overflow;
  bfrlt_pkg::char_info_t info;
  bfrlt_pkg::cmd_t       cmd;
  logic [CNT_W-1:0]      sp_m1;

  assign advance     = st_v_q && !cmd_full_i;
  assign in_ready_o  = !st_v_q || !cmd_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign info        = bfrlt_pkg::classify(in_i.source_byte);
  assign sp_m1       = sp_q - CNT_W'(1);
  assign overflow    = (CMP_W'(sp_q) >= CMP_W'(lim_q)) || (sp_q == CNT_W'(STACK_DEPTH));

  always_comb begin
    pend_v_d    = pend_v_q;
    pend_kind_d = pend_kind_q;
    pend_cnt_d  = pend_cnt_q;
    sp_d        = sp_q;
    label_d     = label_q;
    err_d       = err_q;
    push        = 1'b0;
    pop         = 1'b0;
    do_flush    = 1'b0;
    cmd         = '0;
    cmd.sec     = bfrlt_pkg::SEC_NONE;
    if (accept && !err_q) begin
      priority if (in_i.end_of_input) begin
        do_flush = 1'b1;
        if (sp_q != '0) begin
          cmd.sec        = bfrlt_pkg::SEC_ERR;
          cmd.sec_status = bfrlt_pkg::ST_UNMATCHED;
          err_d          = 1'b1;
        end
      end else if (info.is_op) begin
        if (pend_v_q && pend_kind_q == info.kind && !(&pend_cnt_q)) begin
          pend_cnt_d = pend_cnt_q + COUNT_BITS'(1);
        end else begin
          // start a new run, flushing whatever was pending
          do_flush    = 1'b1;
          pend_kind_d = info.kind;
          pend_cnt_d  = COUNT_BITS'(1);
        end
      end else if (in_i.source_byte == bfrlt_pkg::CHAR_OPEN) begin
        do_flush = 1'b1;
        if (overflow) begin
          cmd.sec        = bfrlt_pkg::SEC_ERR;
          cmd.sec_status = bfrlt_pkg::ST_OVERFLOW;
          err_d          = 1'b1;
        end else begin
          label_d        = label_q + bfrlt_pkg::LABEL_W'(1);
          push           = 1'b1;
          sp_d           = sp_q + CNT_W'(1);
          cmd.sec        = bfrlt_pkg::SEC_OPEN;
          cmd.sec_amount = label_d;
        end
      end else if (in_i.source_byte == bfrlt_pkg::CHAR_CLOSE) begin
        do_flush = 1'b1;
        if (sp_q == '0) begin
          cmd.sec        = bfrlt_pkg::SEC_ERR;
          cmd.sec_status = bfrlt_pkg::ST_UNDERFLOW;
          err_d          = 1'b1;
        end else begin
          // label arrives from the registered stack read, alongside the command
          pop     = 1'b1;
          sp_d    = sp_m1;
          cmd.sec = bfrlt_pkg::SEC_CLOSE;
        end
      end else begin
        do_flush = 1'b1;
      end

      if (do_flush) begin
        cmd.has_run  = pend_v_q;
        cmd.run_kind = pend_kind_q;
        cmd.run_amount = (pend_kind_q == bfrlt_pkg::OP_INPUT) ? '0
                                                              : bfrlt_pkg::AMOUNT_W'(pend_cnt_q);
        pend_v_d = 1'b0;
      end
      if (!in_i.end_of_input && info.is_op) begin
        pend_v_d = 1'b1;
      end
    end
  end

  always_comb begin
    st_v_d = st_v_q;
    st_d   = st_q;
    if (accept) begin
      st_v_d = cmd.has_run || (cmd.sec != bfrlt_pkg::SEC_NONE);
      st_d   = cmd;
    end else if (advance) begin
      st_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= bfrlt_pkg::LIMIT_W'(bfrlt_pkg::LIMIT_RESET);
      pend_v_q    <= 1'b0;
      pend_kind_q <= bfrlt_pkg::OP_ADD;
      pend_cnt_q  <= '0;
      sp_q        <= '0;
      label_q     <= '0;
      err_q       <= 1'b0;
      st_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_data_i;
      end
      pend_v_q    <= pend_v_d;
      pend_kind_q <= pend_kind_d;
      pend_cnt_q  <= pend_cnt_d;
      sp_q        <= sp_d;
      label_q     <= label_d;
      err_q       <= err_d;
      st_v_q      <= st_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  // Label stack: write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[sp_q[SP_W-1:0]] <= label_d;
    end
    if (pop) begin
      rdata_q <= stack_mem[sp_m1[SP_W-1:0]];
    end
  end

  always_comb begin
    cmd_o = st_q;
    if (st_q.sec == bfrlt_pkg::SEC_CLOSE) begin
      cmd_o.sec_amount = rdata_q;
    end
  end

  assign cmd_valid_o = st_v_q;

endmodule

/* src/bfrlt_queue.sv */
module bfrlt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bfrlt_pkg::cmd_t push_data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            pop_i,
  output bfrlt_pkg::cmd_t data_o
);

  bfrlt_pkg::cmd_t                 entry_q [bfrlt_pkg::QUEUE_DEPTH];
  logic [bfrlt_pkg::QPTR_W-1:0]    wptr_q, rptr_q;
  logic [bfrlt_pkg::QCNT_W-1:0]    cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == bfrlt_pkg::QCNT_W'(bfrlt_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + bfrlt_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + bfrlt_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + bfrlt_pkg::QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - bfrlt_pkg::QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* src/bfrlt_back.sv */
module bfrlt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  bfrlt_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bfrlt_pkg::out_t out_o
);

  logic            phase_q, phase_d;
  logic            out_v_q, out_v_d;
  bfrlt_pkg::out_t out_q, out_d;
  logic            load, run_now;
  bfrlt_pkg::out_t res;

  assign load    = cmd_valid_i && (!out_v_q || out_ready_i);
  assign run_now = cmd_i.has_run && !phase_q;

  always_comb begin
    res = '0;
    if (run_now) begin
      res.op_kind = cmd_i.run_kind;
      res.amount  = cmd_i.run_amount;
      res.status  = bfrlt_pkg::ST_OK;
      res.has_op  = 1'b1;
      res.last    = (cmd_i.sec == bfrlt_pkg::SEC_NONE);
    end else begin
      res.last = 1'b1;
      unique case (cmd_i.sec)
        bfrlt_pkg::SEC_OPEN: begin
          res.op_kind = bfrlt_pkg::OP_OPEN;
          res.amount  = cmd_i.sec_amount;
          res.has_op  = 1'b1;
        end
        bfrlt_pkg::SEC_CLOSE: begin
          res.op_kind = bfrlt_pkg::OP_CLOSE;
          res.amount  = cmd_i.sec_amount;
          res.has_op  = 1'b1;
        end
        bfrlt_pkg::SEC_ERR: begin
          res.status = cmd_i.sec_status;
        end
        default: begin
          res.has_op = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    out_v_d   = out_v_q;
    out_d     = out_q;
    cmd_pop_o = 1'b0;
    if (load) begin
      out_v_d = 1'b1;
      out_d   = res;
      if (res.last) begin
        cmd_pop_o = 1'b1;
        phase_d   = 1'b0;
      end else begin
        phase_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

endmodule
